@@ hw/rtl/dpr_pkg.sv @@
// package: codes, types and helpers of the debug packet receiver
`timescale 1ns / 1ps

package dpr_pkg;

	// default buffer size, in payload characters
	localparam int PAYLOAD_CAPACITY_DEF = 256;

	// framing characters
	localparam logic [7:0] CH_START = 8'h24; // '$'
	localparam logic [7:0] CH_END   = 8'h23; // '#'
	localparam logic [7:0] CH_ACK   = 8'h2b; // '+'
	localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
	localparam logic [7:0] CH_NINE  = 8'h39; // '9'
	localparam logic [7:0] CH_UP_A  = 8'h41; // 'A'
	localparam logic [7:0] CH_UP_F  = 8'h46; // 'F'
	localparam logic [7:0] CH_LOW_A = 8'h61; // 'a'
	localparam logic [7:0] HEX_TEN  = 8'h0a;

	// receiver phases
	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_DATA     = 3'd1;
	localparam logic [2:0] PH_CK_HI    = 3'd2;
	localparam logic [2:0] PH_CK_LO    = 3'd3;
	localparam logic [2:0] PH_WAIT_ACK = 3'd4;

	// result events
	localparam logic [2:0] EV_NONE  = 3'd0;
	localparam logic [2:0] EV_BYTE  = 3'd1;
	localparam logic [2:0] EV_START = 3'd2;
	localparam logic [2:0] EV_GOOD  = 3'd3;
	localparam logic [2:0] EV_EMPTY = 3'd4;
	localparam logic [2:0] EV_NAK   = 3'd5;
	localparam logic [2:0] EV_ACK   = 3'd6;
	localparam logic [2:0] EV_RETX  = 3'd7;

	// input function codes
	localparam logic FUNC_RX    = 1'b0;
	localparam logic FUNC_REPLY = 1'b1;

	typedef struct packed {
		logic [2:0] event_res;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [8:0] packet_length;
	} dpr_result_t;

	// lenient hex decode: anything not a digit or upper-case letter is taken as lower case
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				v = c - CH_ZERO;
			end else if (c >= CH_UP_A && c <= CH_UP_F) begin
				v = c - CH_UP_A + HEX_TEN;
			end else begin
				v = c - CH_LOW_A + HEX_TEN;
			end
			return v[3:0];
		end
	endfunction

endpackage

@@ hw/rtl/dpr_in_if.sv @@
// interface: input word channel of the debug packet receiver
`timescale 1ns / 1ps

interface dpr_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] rx_byte;

	modport source (output valid, output func, output rx_byte, input ready);
	modport sink (input valid, input func, input rx_byte, output ready);
endinterface

@@ hw/rtl/dpr_out_if.sv @@
// interface: result word channel of the debug packet receiver
`timescale 1ns / 1ps

interface dpr_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;
	logic [8:0] packet_length;

	modport source (output valid, output event_res, output payload_byte,
		output payload_index, output packet_length, input ready);
	modport sink (input valid, input event_res, input payload_byte,
		input payload_index, input packet_length, output ready);
endinterface

@@ hw/rtl/debug_packet_receiver.sv @@
// top level: framed debug packet receiver with checksum check and ack wait
`timescale 1ns / 1ps

//  channel  | dir | words                          | handshake
//  ---------+-----+--------------------------------+-----------------------
//  item     | in  | func, rx_byte                  | valid/ready, accepted
//           |     |                                | when both are high
//  result   | out | event_res, payload_byte,       | valid/ready, one word
//           |     | payload_index, packet_length   | per accepted item
//
// one item per cycle while item.ready is high: the phase logic is a single pass from the accepted word
// to the result register, or to the skid register while the output is stalled.
// a two-entry output (result register plus skid register) keeps item.ready
// high while one result waits; item.ready drops only when both are full.
// arst_n clears phase, length, sum, high nibble and both valid flags.

module debug_packet_receiver #(
	parameter int PAYLOAD_CAPACITY = dpr_pkg::PAYLOAD_CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	dpr_in_if.sink     item,
	dpr_out_if.source  result
);
	import dpr_pkg::*;

	// length counter must hold the capacity itself
	localparam int LEN_W = $clog2(PAYLOAD_CAPACITY + 1);

	// receiver state
	logic [2:0]       phase_q;
	logic [LEN_W-1:0] len_q;
	logic [7:0]       sum_q;
	logic [3:0]       hi_nib_q;

	// output register and skid register
	logic        out_vld_q;
	dpr_result_t out_q;
	logic        skid_vld_q;
	dpr_result_t skid_q;

	// next state and result of the accepted word
	logic [2:0]       phase_d;
	logic [LEN_W-1:0] len_d;
	logic [7:0]       sum_d;
	logic [3:0]       hi_nib_d;
	dpr_result_t      res_d;

	logic             accept;
	logic [LEN_W+8:0] len_ext;
	logic [7:0]       theirs;

	assign item.ready = !skid_vld_q;
	assign accept     = item.valid && item.ready;

	// zero-extend the counter so the fixed-width fields take their low bits
	assign len_ext = {9'd0, len_q};
	assign theirs  = {hi_nib_q, hex_value(item.rx_byte)};

	// phase logic, one pass per word
	always_comb begin
		phase_d  = phase_q;
		len_d    = len_q;
		sum_d    = sum_q;
		hi_nib_d = hi_nib_q;
		res_d    = '0;
		res_d.event_res = EV_NONE;

		if (item.func == FUNC_REPLY) begin
			// reply went out: abandon anything in progress and wait for '+'
			phase_d = PH_WAIT_ACK;
		end else begin
			case (phase_q)
				PH_DATA: begin
					if (item.rx_byte == CH_END) begin
						phase_d = PH_CK_HI;
					end else if (item.rx_byte == CH_START) begin
						// restart inside a packet
						len_d = '0;
						sum_d = '0;
						res_d.event_res = EV_START;
					end else if (len_q < LEN_W'(PAYLOAD_CAPACITY)) begin
						res_d.event_res     = EV_BYTE;
						res_d.payload_byte  = item.rx_byte;
						res_d.payload_index = len_ext[7:0];
						len_d = len_q + LEN_W'(1);
						sum_d = sum_q + item.rx_byte;
					end
					// buffer full: byte dropped, sum untouched
				end
				PH_CK_HI: begin
					hi_nib_d = hex_value(item.rx_byte);
					phase_d  = PH_CK_LO;
				end
				PH_CK_LO: begin
					phase_d = PH_IDLE;
					res_d.packet_length = len_ext[8:0];
					if (theirs == sum_q) begin
						res_d.event_res = (len_q != '0) ? EV_GOOD : EV_EMPTY;
					end else begin
						res_d.event_res = EV_NAK;
					end
				end
				PH_WAIT_ACK: begin
					if (item.rx_byte == CH_ACK) begin
						phase_d = PH_IDLE;
						res_d.event_res = EV_ACK;
					end else begin
						res_d.event_res = EV_RETX;
					end
				end
				default: begin
					// idle: only '$' opens a packet, all else is noise
					phase_d = PH_IDLE;
					if (item.rx_byte == CH_START) begin
						len_d   = '0;
						sum_d   = '0;
						phase_d = PH_DATA;
						res_d.event_res = EV_START;
					end
				end
			endcase
		end
	end

	// state update on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			len_q    <= '0;
			sum_q    <= '0;
			hi_nib_q <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			len_q    <= len_d;
			sum_q    <= sum_d;
			hi_nib_q <= hi_nib_d;
		end
	end

	// output valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_vld_q && !result.ready) begin
			// output stalled: a new word parks in the skid register
			if (accept) begin
				skid_vld_q <= 1'b1;
			end
		end else if (skid_vld_q) begin
			// skid drains first, no word accepted meanwhile
			out_vld_q  <= 1'b1;
			skid_vld_q <= 1'b0;
		end else begin
			out_vld_q <= accept;
		end
	end

	// output payload, no reset needed
	always_ff @(posedge clk) begin
		if (out_vld_q && !result.ready) begin
			if (accept) begin
				skid_q <= res_d;
			end
		end else if (skid_vld_q) begin
			out_q <= skid_q;
		end else if (accept) begin
			out_q <= res_d;
		end
	end

	assign result.valid         = out_vld_q;
	assign result.event_res     = out_q.event_res;
	assign result.payload_byte  = out_q.payload_byte;
	assign result.payload_index = out_q.payload_index;
	assign result.packet_length = out_q.packet_length;

endmodule

@@ hw/rtl/dpr_checker.sv @@
// checker: port-level assertions for the debug packet receiver, with bind
`timescale 1ns / 1ps

module dpr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [2:0] event_res,
	input logic [7:0] payload_byte,
	input logic [7:0] payload_index,
	input logic [8:0] packet_length
);
	import dpr_pkg::*;

	// a waiting result stays until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result word dropped while stalled");

	// input back-pressure only when a result is pending
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid)
		else $error("input stalled with no result pending");

	// byte fields are zero unless a payload byte is reported
	a_byte_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && event_res != EV_BYTE |-> payload_byte == 8'd0 && payload_index == 8'd0)
		else $error("payload fields set outside a byte event");

	// length field only on checksum verdicts
	a_len_field: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && event_res != EV_GOOD && event_res != EV_EMPTY && event_res != EV_NAK
		|-> packet_length == 9'd0)
		else $error("packet length set outside a verdict");

	// empty verdict carries no length
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && event_res == EV_EMPTY |-> packet_length == 9'd0)
		else $error("empty packet with nonzero length");

endmodule

bind debug_packet_receiver dpr_checker u_dpr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_ready    (item.ready),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.event_res     (result.event_res),
	.payload_byte  (result.payload_byte),
	.payload_index (result.payload_index),
	.packet_length (result.packet_length)
);

@@ tb/tb_debug_packet_receiver.sv @@
// testbench: debug packet receiver checked word by word against a frame-level predictor
`timescale 1ns / 1ps

module tb_debug_packet_receiver;
	import dpr_pkg::*;

	// buffer size the block is built with
	localparam int CAP = PAYLOAD_CAPACITY_DEF;
	// rough number of input words to send
	localparam int WORD_TARGET = 650;
	// no idling on either side once this few words are left to send
	localparam int CALM_WORDS = 60;
	// longest legal stretch with no word accepted is the long output hold
	localparam int QUIET_LIMIT = 1000;
	// results accepted before the long output hold starts
	localparam int HOLD_AFTER = 150;
	localparam int HOLD_CYCLES = 80;

	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
	} rx_word_t;

	logic clk;
	logic arst_n;

	dpr_in_if  rx_ch ();
	dpr_out_if ev_ch ();

	debug_packet_receiver #(
		.PAYLOAD_CAPACITY(CAP)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (rx_ch),
		.result (ev_ch)
	);

	// words waiting to be sent, and result words still owed by the block
	rx_word_t    pending_words[$];
	dpr_result_t expected_results[$];

	// predictor state: receiver phase, stored payload length, running sum, first checksum digit
	logic [2:0]  rx_phase = PH_IDLE;
	logic [12:0] frame_len = '0;
	logic [7:0]  frame_sum = '0;
	logic [3:0]  ck_high = '0;

	int  err_count = 0;
	int  results_seen = 0;
	int  quiet_cycles = 0;
	bit  word_taken = 0;

	// sender side idling
	int       send_gap = 0;
	int       send_odds = 0;
	int       send_tick = 0;
	rx_word_t next_word;

	// receiver side idling, plus the one long hold-off
	int take_gap = 0;
	int take_odds = 0;
	int take_tick = 0;
	int hold_left = 0;
	bit hold_done = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// lenient hex digit: digits and upper-case letters as usual, anything else read as lower case
	function automatic logic [3:0] digit_of(input logic [7:0] c);
		logic [7:0] d;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
		end else if (c >= CH_UP_A && c <= CH_UP_F) begin
			d = c - CH_UP_A + HEX_TEN;
		end else begin
			d = c + HEX_TEN - CH_LOW_A;
		end
		return d[3:0];
	endfunction

	// advance the predictor by one accepted word and queue the result it owes
	task automatic predict_word(input logic f, input logic [7:0] c);
		dpr_result_t r;
		logic [7:0]  theirs;
		r = '0;
		if (f == FUNC_REPLY) begin
			// reply notice abandons any frame in progress; length and sum survive
			rx_phase = PH_WAIT_ACK;
		end else begin
			case (rx_phase)
				PH_DATA: begin
					if (c == CH_END) begin
						rx_phase = PH_CK_HI;
					end else if (c == CH_START) begin
						// restart inside a frame
						frame_len = '0;
						frame_sum = '0;
						r.event_res = EV_START;
					end else if (frame_len < CAP) begin
						r.event_res = EV_BYTE;
						r.payload_byte = c;
						r.payload_index = frame_len[7:0];
						frame_len = frame_len + 1'b1;
						frame_sum = frame_sum + c;
					end
					// past capacity the byte is dropped silently
				end
				PH_CK_HI: begin
					ck_high = digit_of(c);
					rx_phase = PH_CK_LO;
				end
				PH_CK_LO: begin
					theirs = {ck_high, digit_of(c)};
					rx_phase = PH_IDLE;
					r.packet_length = frame_len[8:0];
					if (theirs != frame_sum) begin
						r.event_res = EV_NAK;
					end else if (frame_len != 0) begin
						r.event_res = EV_GOOD;
					end else begin
						r.event_res = EV_EMPTY;
					end
				end
				PH_WAIT_ACK: begin
					if (c == CH_ACK) begin
						rx_phase = PH_IDLE;
						r.event_res = EV_ACK;
					end else begin
						r.event_res = EV_RETX;
					end
				end
				default: begin
					rx_phase = PH_IDLE;
					if (c == CH_START) begin
						frame_len = '0;
						frame_sum = '0;
						rx_phase = PH_DATA;
						r.event_res = EV_START;
					end
				end
			endcase
		end
		expected_results.push_back(r);
	endtask

	// ---------------- stimulus building ----------------

	task automatic put_word(input logic f, input logic [7:0] c);
		rx_word_t w;
		w.func = f;
		w.rx_byte = c;
		pending_words.push_back(w);
	endtask

	// any byte that neither ends nor restarts a frame
	function automatic logic [7:0] payload_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (c == CH_END || c == CH_START);
		return c;
	endfunction

	// spell a nibble as a digit, upper or lower case letter, or an odd character that decodes to it
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] c;
		int         style;
		style = $urandom_range(0, 3);
		if (n < 10 && style < 2) begin
			c = CH_ZERO + n;
		end else if (n >= 10 && style == 0) begin
			c = CH_UP_A + n - HEX_TEN;
		end else if (style == 3) begin
			c = CH_LOW_A - HEX_TEN + n + 8'(16 * $urandom_range(0, 15));
			if ((c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UP_A && c <= CH_UP_F)) begin
				c = CH_LOW_A - HEX_TEN + n;
			end
		end else begin
			c = CH_LOW_A - HEX_TEN + n;
		end
		return c;
	endfunction

	// one '$payload#hh' frame; a restart drops what came before it in the frame
	task automatic put_frame(input int n, input bit good, input bit restart);
		logic [7:0] c;
		logic [7:0] sum;
		logic [7:0] theirs;
		int         kept;
		sum = '0;
		kept = 0;
		put_word(FUNC_RX, CH_START);
		for (int i = 0; i < n; i++) begin
			if (restart && i == n / 2) begin
				put_word(FUNC_RX, CH_START);
				sum = '0;
				kept = 0;
			end
			c = payload_char();
			put_word(FUNC_RX, c);
			if (kept < CAP) begin
				sum = sum + c;
				kept++;
			end
		end
		put_word(FUNC_RX, CH_END);
		theirs = good ? sum : sum ^ (8'h01 << $urandom_range(0, 7));
		put_word(FUNC_RX, hex_char(theirs[7:4]));
		put_word(FUNC_RX, hex_char(theirs[3:0]));
	endtask

	// reply notice, a few refused bytes, then the acknowledge
	task automatic put_reply(input int refusals);
		logic [7:0] c;
		put_word(FUNC_REPLY, 8'($urandom_range(0, 255)));
		for (int i = 0; i < refusals; i++) begin
			do begin
				c = 8'($urandom_range(0, 255));
			end while (c == CH_ACK);
			put_word(FUNC_RX, c);
		end
		put_word(FUNC_RX, CH_ACK);
	endtask

	task automatic put_directed();
		put_word(FUNC_RX, CH_LOW_A);      // idle noise
		put_word(FUNC_REPLY, 8'hff);      // reply notice from idle
		put_word(FUNC_RX, 8'h00);         // not an ack: retransmit
		put_word(FUNC_RX, CH_ACK);
		put_word(FUNC_RX, CH_START);
		put_word(FUNC_RX, 8'h00);
		put_word(FUNC_RX, 8'hff);
		put_word(FUNC_RX, CH_START);      // restart clears length and sum
		put_word(FUNC_RX, 8'h7e);
		put_word(FUNC_RX, CH_END);
		put_word(FUNC_RX, CH_ZERO + 8'd7);
		put_word(FUNC_RX, CH_LOW_A + 8'd4);  // 'e', good with dispatch
		put_word(FUNC_RX, CH_START);
		put_word(FUNC_RX, CH_END);
		put_word(FUNC_RX, CH_ZERO);
		put_word(FUNC_RX, CH_ZERO);       // good, empty payload
		put_word(FUNC_RX, CH_START);
		put_word(FUNC_RX, 8'h01);
		put_word(FUNC_RX, CH_END);
		put_word(FUNC_RX, CH_ZERO);
		put_word(FUNC_RX, 8'h58);         // 'X' decodes leniently to 1: good
		put_word(FUNC_RX, CH_START);
		put_word(FUNC_RX, CH_UP_A);
		put_word(FUNC_RX, CH_END);
		put_word(FUNC_RX, CH_UP_F);
		put_word(FUNC_RX, CH_UP_F);       // sum 0x41 against 0xff: nak
		put_word(FUNC_RX, CH_START);
		put_word(FUNC_RX, 8'h71);
		put_word(FUNC_REPLY, 8'h00);      // reply notice in the middle of a frame
		put_word(FUNC_RX, CH_ACK);
	endtask

	task automatic put_random();
		int pick;
		// one frame that runs past the buffer, then mostly well-formed traffic
		put_frame($urandom_range(CAP + 1, CAP + 6), 1'b1, 1'b0);
		put_reply(0);
		while (pending_words.size() < WORD_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				put_frame(($urandom_range(0, 5) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8),
					$urandom_range(0, 6) != 0, 1'b0);
				if ($urandom_range(0, 9) < 7) begin
					put_reply($urandom_range(0, 2));
				end
			end else if (pick < 65) begin
				put_frame($urandom_range(2, 12), $urandom_range(0, 3) != 0, 1'b1);
			end else if (pick < 75) begin
				// idle noise, a stray start possible
				repeat ($urandom_range(1, 4)) put_word(FUNC_RX, 8'($urandom_range(0, 255)));
			end else if (pick < 85) begin
				// frame broken by a reply notice or cut short
				put_word(FUNC_RX, CH_START);
				repeat ($urandom_range(0, 5)) put_word(FUNC_RX, payload_char());
				if ($urandom_range(0, 1) == 0) begin
					put_word(FUNC_RX, CH_END);
					put_word(FUNC_RX, 8'($urandom_range(0, 255)));
				end
				put_reply($urandom_range(0, 1));
			end else if (pick < 92) begin
				put_reply($urandom_range(1, 4));
			end else begin
				put_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	// ---------------- sender ----------------

	always @(negedge clk) begin
		// idle odds re-picked periodically: 0 means no idling in that stretch
		send_tick++;
		if (send_tick % 64 == 0) begin
			case ($urandom_range(0, 2))
				0: send_odds = 0;
				1: send_odds = 3;
				default: send_odds = 10;
			endcase
		end
		if (!arst_n) begin
			rx_ch.valid <= 1'b0;
		end else if (!rx_ch.valid || word_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				rx_ch.valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				next_word = pending_words.pop_front();
				rx_ch.valid <= 1'b1;
				rx_ch.func <= next_word.func;
				rx_ch.rx_byte <= next_word.rx_byte;
				// a gap, if any, follows once this word is taken
				if (send_odds != 0 && pending_words.size() > CALM_WORDS &&
					$urandom_range(1, send_odds) == 1) begin
					send_gap = $urandom_range(1, 13);
				end
			end else begin
				rx_ch.valid <= 1'b0;
			end
		end
	end

	// ---------------- receiver ----------------

	always @(negedge clk) begin
		take_tick++;
		if (take_tick % 64 == 32) begin
			case ($urandom_range(0, 2))
				0: take_odds = 0;
				1: take_odds = 3;
				default: take_odds = 12;
			endcase
		end
		if (!arst_n) begin
			ev_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			ev_ch.ready <= 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			// long hold-off: the sender keeps offering until the block backs up
			hold_done = 1;
			hold_left = HOLD_CYCLES - 1;
			ev_ch.ready <= 1'b0;
		end else if (take_gap > 0) begin
			take_gap--;
			ev_ch.ready <= 1'b0;
		end else if (take_odds != 0 && pending_words.size() > CALM_WORDS &&
			$urandom_range(1, take_odds) == 1) begin
			take_gap = $urandom_range(0, 12);
			ev_ch.ready <= 1'b0;
		end else begin
			ev_ch.ready <= 1'b1;
		end
	end

	// ---------------- monitor and checker ----------------

	always @(posedge clk) begin
		dpr_result_t want;
		word_taken = 0;
		if (arst_n) begin
			// check the output first so a result can never match a word taken at this same edge
			if (ev_ch.valid && ev_ch.ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result word with nothing expected: event_res %0d", ev_ch.event_res);
					err_count++;
				end else begin
					want = expected_results.pop_front();
					if (ev_ch.event_res !== want.event_res) begin
						$error("event_res: expected %0d, got %0d", want.event_res, ev_ch.event_res);
						err_count++;
					end
					if (ev_ch.payload_byte !== want.payload_byte) begin
						$error("payload_byte: expected %0h, got %0h",
							want.payload_byte, ev_ch.payload_byte);
						err_count++;
					end
					if (ev_ch.payload_index !== want.payload_index) begin
						$error("payload_index: expected %0d, got %0d",
							want.payload_index, ev_ch.payload_index);
						err_count++;
					end
					if (ev_ch.packet_length !== want.packet_length) begin
						$error("packet_length: expected %0d, got %0d",
							want.packet_length, ev_ch.packet_length);
						err_count++;
					end
				end
			end
			if (rx_ch.valid && rx_ch.ready) begin
				predict_word(rx_ch.func, rx_ch.rx_byte);
				word_taken = 1;
			end
		end
	end

	// watchdog: too long without any word moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (rx_ch.valid && rx_ch.ready) || (ev_ch.valid && ev_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// ---------------- run control ----------------

	initial begin
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.func = FUNC_RX;
		rx_ch.rx_byte = 8'h00;
		ev_ch.ready = 1'b0;
		put_directed();
		put_random();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		// drain: every word sent and every owed result seen
		while (pending_words.size() != 0 || rx_ch.valid || expected_results.size() != 0) begin
			@(negedge clk);
		end
		// then wait on to catch any stray result
		repeat (10) @(negedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			err_count++;
		end
		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
